>>> design/md5_pkg.sv
// md5_pkg: shared types, constants and round functions of the md5 digest block
// used by md5_front, md5_fifo, md5_back and md5_message_digest; no dependencies
package md5_pkg;

	// default depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// item modes, also used as job kinds in the queue
	localparam logic [1:0] MODE_DATA  = 2'd0;
	localparam logic [1:0] MODE_FINAL = 2'd1;
	localparam logic [1:0] MODE_END   = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// input beat
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
	} in_item_t;

	// output beat
	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last;
	} out_item_t;

	// queued job: kind is one of the item modes other than MODE_NONE
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
	} job_t;

	// push request from front to queue
	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	// pop side of the queue as seen by the back
	typedef struct packed {
		logic valid;
		job_t job;
	} head_t;

	localparam logic [31:0] INIT_WORDS [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [4:0] SHIFT_TABLE [4][4] = '{
		'{5'd7, 5'd12, 5'd17, 5'd22},
		'{5'd5, 5'd9,  5'd14, 5'd20},
		'{5'd4, 5'd11, 5'd16, 5'd23},
		'{5'd6, 5'd10, 5'd15, 5'd21}
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// nonlinear function of the round group
	function automatic logic [31:0] round_f(input logic [5:0] i, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (i[5:4])
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (d & b) | (~d & c);
			2'd2: f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

	// message word used by a round
	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = i[3:0] * 4'd5 + 4'd1;
			2'd2: g = i[3:0] * 4'd3 + 4'd5;
			default: g = i[3:0] * 4'd7;
		endcase
		return g;
	endfunction

	// rotate amount of a round
	function automatic logic [4:0] shift_amount(input logic [5:0] i);
		return SHIFT_TABLE[i[5:4]][i[1:0]];
	endfunction

	// left rotate by a nonzero amount
	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] t;
		t = {x, x} << s;
		return t[63:32];
	endfunction

endpackage

>>> design/md5_message_digest.sv
// md5_message_digest: top level of the md5 digest block
// depends on md5_pkg, md5_front, md5_fifo, md5_back
//
// Usage: the item channel (item_valid, item_stall, item) carries one message byte
// per beat, mode data or final data, or an end-of-message beat with no byte; the
// unused mode is taken and dropped. The digest channel (digest_valid,
// digest_stall, digest) returns four 32-bit words A, B, C, D with word_index
// 0..3 and last set on D, once per message.
// Sequence: every 64th byte starts a compression, the round loop of the single
// round unit followed by an add into the chaining words; the back takes no
// jobs while it runs. After the ending beat the padding sequencer writes one
// pad byte per cycle up to position 56, except while a compression runs, then
// the length words; one or two compressions follow (two when the pad spills
// into a second block), then four digest beats.
// A queue of QUEUE_DEPTH jobs sits between the input register and the back,
// so bytes keep being taken while a compression runs until it fills.
// Reset loads the standard initial chaining words and clears the length;
// the block is ready right after reset. A stall on the digest channel holds
// the current word; input beats are taken until the queue fills.
module md5_message_digest #(
	parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  md5_pkg::in_item_t  item,
	output logic               digest_valid,
	input  logic               digest_stall,
	output md5_pkg::out_item_t digest
);

	md5_pkg::push_t push;
	md5_pkg::head_t head;
	logic           full;
	logic           pop;

	// input register and classification
	md5_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.full       (full)
	);

	// job queue
	md5_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	// buffer, padding, rounds and output
	md5_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

endmodule

>>> design/md5_front.sv
// md5_front: input stage that takes item beats, drops unused modes and feeds the queue
// depends on md5_pkg
module md5_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  md5_pkg::in_item_t item,
	output md5_pkg::push_t   push,
	input  logic             full
);

	logic          valid_s1;
	md5_pkg::job_t job_s1;
	logic          accept;

	// hold a beat while the queue is full
	assign item_stall = valid_s1 && full;
	assign accept     = item_valid && !item_stall;

	assign push.valid = valid_s1;
	assign push.job   = job_s1;

	// classify: a beat of the unused mode is taken and dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (item.mode != md5_pkg::MODE_NONE);
		end else if (valid_s1 && !full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.kind      <= item.mode;
			job_s1.data_byte <= item.data_byte;
		end
	end

endmodule

>>> design/md5_fifo.sv
// md5_fifo: short job queue between the front and the back
// depends on md5_pkg
module md5_fifo #(
	parameter int DEPTH = md5_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  md5_pkg::push_t push,
	output logic           full,
	input  logic           pop,
	output md5_pkg::head_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	md5_pkg::job_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head.valid = (count_q != '0);
	assign head.job   = entry_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.job;
		end
	end

endmodule

>>> design/md5_back.sv
// md5_back: block buffer, padding sequencer, round unit and digest output
// depends on md5_pkg
module md5_back (
	input  logic               clk,
	input  logic               arst_n,
	input  md5_pkg::head_t     head,
	output logic               pop,
	output logic               digest_valid,
	input  logic               digest_stall,
	output md5_pkg::out_item_t digest
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD80 = 3'd1;
	localparam logic [2:0] ST_PADZ  = 3'd2;
	localparam logic [2:0] ST_COMP  = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [5:0] POS_LAST = 6'd63;
	localparam logic [5:0] POS_LEN  = 6'd56;

	logic [2:0]  state_q;
	logic [2:0]  ret_q;
	logic [31:0] chain_q [4];
	logic [31:0] rw_q [4];
	logic [31:0] blk_q [16];
	logic [60:0] msg_q;
	logic [5:0]  round_q;
	logic [5:0]  pad_pos_q;
	logic [1:0]  word_idx_q;

	logic        bw_en;
	logic [5:0]  bw_pos;
	logic [7:0]  bw_byte;
	logic        len_en;
	logic [63:0] bit_len;
	logic        is_end;
	logic [31:0] f_val;
	logic [31:0] sum;
	logic [31:0] new_b;

	assign bit_len = {msg_q, 3'b000};
	assign is_end  = (head.job.kind == md5_pkg::MODE_END);

	// queue pop, byte writes and length write into the block buffer
	always_comb begin
		pop     = 1'b0;
		bw_en   = 1'b0;
		bw_pos  = msg_q[5:0];
		bw_byte = head.job.data_byte;
		len_en  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop   = 1'b1;
					bw_en = !is_end;
				end
			end
			ST_PAD80: begin
				bw_en   = 1'b1;
				bw_byte = 8'h80;
			end
			ST_PADZ: begin
				bw_pos  = pad_pos_q;
				bw_byte = 8'h00;
				if (pad_pos_q == POS_LEN) begin
					len_en = 1'b1;
				end else begin
					bw_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// one md5 round
	always_comb begin
		f_val = md5_pkg::round_f(round_q, rw_q[1], rw_q[2], rw_q[3]);
		sum   = rw_q[0] + f_val + md5_pkg::ROUND_K[round_q] + blk_q[md5_pkg::msg_index(round_q)];
		new_b = rw_q[1] + md5_pkg::rotl32(sum, md5_pkg::shift_amount(round_q));
	end

	// block buffer, little-endian byte lanes
	always_ff @(posedge clk) begin
		if (bw_en) begin
			unique case (bw_pos[1:0])
				2'd0: blk_q[bw_pos[5:2]] <= {24'h000000, bw_byte};
				2'd1: blk_q[bw_pos[5:2]][15:8] <= bw_byte;
				2'd2: blk_q[bw_pos[5:2]][23:16] <= bw_byte;
				default: blk_q[bw_pos[5:2]][31:24] <= bw_byte;
			endcase
		end
		if (len_en) begin
			blk_q[14] <= bit_len[31:0];
			blk_q[15] <= bit_len[63:32];
		end
	end

	// sequencer, chaining and working words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_q      <= ST_IDLE;
			msg_q      <= '0;
			round_q    <= '0;
			pad_pos_q  <= '0;
			word_idx_q <= '0;
			for (int j = 0; j < 4; j++) begin
				chain_q[j] <= md5_pkg::INIT_WORDS[j];
				rw_q[j]    <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						if (is_end) begin
							state_q <= ST_PAD80;
						end else begin
							msg_q <= msg_q + 1'b1;
							if (msg_q[5:0] == POS_LAST) begin
								state_q <= ST_COMP;
								ret_q   <= (head.job.kind == md5_pkg::MODE_FINAL) ?
									ST_PAD80 : ST_IDLE;
								rw_q    <= chain_q;
							end else begin
								state_q <= (head.job.kind == md5_pkg::MODE_FINAL) ?
									ST_PAD80 : ST_IDLE;
							end
						end
					end
				end
				ST_PAD80: begin
					pad_pos_q <= msg_q[5:0] + 1'b1;
					if (msg_q[5:0] == POS_LAST) begin
						state_q <= ST_COMP;
						ret_q   <= ST_PADZ;
						rw_q    <= chain_q;
					end else begin
						state_q <= ST_PADZ;
					end
				end
				ST_PADZ: begin
					if (pad_pos_q == POS_LEN) begin
						state_q <= ST_COMP;
						ret_q   <= ST_OUT;
						rw_q    <= chain_q;
					end else begin
						pad_pos_q <= pad_pos_q + 1'b1;
						if (pad_pos_q == POS_LAST) begin
							state_q <= ST_COMP;
							ret_q   <= ST_PADZ;
							rw_q    <= chain_q;
						end
					end
				end
				ST_COMP: begin
					rw_q[0] <= rw_q[3];
					rw_q[1] <= new_b;
					rw_q[2] <= rw_q[1];
					rw_q[3] <= rw_q[2];
					round_q <= round_q + 1'b1;
					if (round_q == POS_LAST) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int j = 0; j < 4; j++) begin
						chain_q[j] <= chain_q[j] + rw_q[j];
					end
					word_idx_q <= '0;
					state_q    <= ret_q;
				end
				ST_OUT: begin
					if (!digest_stall) begin
						word_idx_q <= word_idx_q + 1'b1;
						if (word_idx_q == 2'd3) begin
							state_q <= ST_IDLE;
							msg_q   <= '0;
							for (int j = 0; j < 4; j++) begin
								chain_q[j] <= md5_pkg::INIT_WORDS[j];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// digest beats straight from the chaining words
	assign digest_valid       = (state_q == ST_OUT);
	assign digest.digest_word = chain_q[word_idx_q];
	assign digest.word_index  = word_idx_q;
	assign digest.last        = (word_idx_q == 2'd3);

	// round counter only moves during a compression
	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(round_q != '0) |-> (state_q == ST_COMP))
		else $error("round counter nonzero outside compression");

	// the final beat restores the initial chaining words
	a_last_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && digest.last) |=>
		(state_q == ST_IDLE && chain_q[0] == md5_pkg::INIT_WORDS[0] && msg_q == '0))
		else $error("digest end did not reload state");

	// jobs leave the queue only when the sequencer is idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE && head.valid))
		else $error("queue popped while busy");

	// the length words go in only right before the last compression
	a_len_final: assert property (@(posedge clk) disable iff (!arst_n)
		len_en |=> (state_q == ST_COMP && ret_q == ST_OUT && round_q == '0))
		else $error("length written outside final block");

endmodule

>>> bench/testbench.sv
// testbench: self-checking bench for md5_message_digest, byte-serial md5 with digest beats
// keeps its own md5 state to predict digests; depends on md5_pkg and the design files
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 12;

	// per-round additive constants
	localparam bit [31:0] RND_CONST [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// rotate amounts, by round group and round within group
	localparam int ROT_AMT [4][4] = '{
		'{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
	};

	localparam bit [31:0] CHAIN_INIT [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	md5_pkg::in_item_t  item;
	logic               digest_valid;
	logic               digest_stall;
	md5_pkg::out_item_t digest;

	// predicted md5 state
	bit [31:0] msg_block [16];
	bit [31:0] chain [4];
	bit [60:0] byte_count;

	md5_pkg::out_item_t digest_q [$];
	int                 errors;
	int                 cycles;
	int                 stall_left;
	int                 hold_off;
	bit                 idle_on;

	md5_message_digest dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	// clock, 8 ns period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic bit [31:0] rol32(bit [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// one 64-round compression of msg_block into chain
	task automatic md5_compress();
		bit [31:0] a, b, c, d, f, t;
		int g;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (int i = 0; i < 64; i++) begin
			case (i / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			t = d;
			d = c;
			c = b;
			b = b + rol32(a + f + RND_CONST[i] + msg_block[g], ROT_AMT[i / 16][i % 4]);
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
	endtask

	// place one byte little-endian in the block, compress when it is full
	task automatic md5_absorb_byte(int pos, bit [7:0] v);
		if (pos % 4 == 0)
			msg_block[pos / 4] = {24'h0, v};
		else
			msg_block[pos / 4] |= {24'h0, v} << (8 * (pos % 4));
		if (pos == 63)
			md5_compress();
	endtask

	task automatic md5_reset_state();
		foreach (msg_block[j])
			msg_block[j] = '0;
		foreach (chain[j])
			chain[j] = CHAIN_INIT[j];
		byte_count = '0;
	endtask

	// advance the predicted state by one accepted beat, queue any digest
	task automatic md5_take_item(md5_pkg::in_item_t it);
		bit [63:0] bit_len;
		int pos;
		md5_pkg::out_item_t w;
		if (it.mode == md5_pkg::MODE_NONE)
			return;
		if (it.mode == md5_pkg::MODE_DATA || it.mode == md5_pkg::MODE_FINAL) begin
			md5_absorb_byte(int'(byte_count[5:0]), it.data_byte);
			byte_count = byte_count + 61'd1;
			if (it.mode == md5_pkg::MODE_DATA)
				return;
		end
		bit_len = {byte_count, 3'b000};
		pos = int'(byte_count[5:0]);
		md5_absorb_byte(pos, 8'h80);
		pos = (pos + 1) % 64;
		while (pos != 56) begin
			md5_absorb_byte(pos, 8'h00);
			pos = (pos + 1) % 64;
		end
		msg_block[14] = bit_len[31:0];
		msg_block[15] = bit_len[63:32];
		md5_compress();
		for (int j = 0; j < 4; j++) begin
			w.digest_word = chain[j];
			w.word_index  = 2'(j);
			w.last        = (j == 3);
			digest_q.push_back(w);
			chain[j] = CHAIN_INIT[j];
		end
		byte_count = '0;
	endtask

	// send one beat: entered and left at a falling edge
	task automatic send_item(logic [1:0] mode, logic [7:0] data);
		int gap;
		md5_pkg::in_item_t it;
		it.mode      = mode;
		it.data_byte = data;
		gap = idle_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (item_stall);
		md5_take_item(it);
		@(negedge clk);
	endtask

	// a whole message of random bytes, ended by a final byte or an end beat
	task automatic send_message(int len, bit end_on_byte, bit noise);
		for (int k = 0; k < len; k++) begin
			if (noise && $urandom_range(0, 15) == 0)
				send_item(md5_pkg::MODE_NONE, 8'($urandom));
			if (end_on_byte && k == len - 1)
				send_item(md5_pkg::MODE_FINAL, 8'($urandom));
			else
				send_item(md5_pkg::MODE_DATA, 8'($urandom));
		end
		if (!end_on_byte || len == 0)
			send_item(md5_pkg::MODE_END, 8'($urandom));
	endtask

	// digest checker
	always @(posedge clk) begin
		md5_pkg::out_item_t want;
		if (arst_n && digest_valid && !digest_stall) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest beat %h", $time, digest);
				errors++;
			end else begin
				want = digest_q.pop_front();
				if (digest.digest_word !== want.digest_word) begin
					$display("%0t: digest_word expected %h actual %h",
						$time, want.digest_word, digest.digest_word);
					errors++;
				end
				if (digest.word_index !== want.word_index) begin
					$display("%0t: word_index expected %0d actual %0d",
						$time, want.word_index, digest.word_index);
					errors++;
				end
				if (digest.last !== want.last) begin
					$display("%0t: last expected %0d actual %0d",
						$time, want.last, digest.last);
					errors++;
				end
			end
			stall_left = idle_on ? $urandom_range(0, 6) : 0;
		end
	end

	// digest receiver: random stalls, plus a long hold-off on request
	initial begin
		digest_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				digest_stall <= 1'b1;
				hold_off--;
			end else if (stall_left > 0) begin
				digest_stall <= 1'b1;
				stall_left--;
			end else begin
				digest_stall <= 1'b0;
			end
		end
	end

	// empty message, one byte, "abc", byte extremes, ignored mode
	task automatic test_short_messages();
		send_item(md5_pkg::MODE_END, 8'hff);
		send_item(md5_pkg::MODE_FINAL, 8'hff);
		send_item(md5_pkg::MODE_DATA, 8'h61);
		send_item(md5_pkg::MODE_DATA, 8'h62);
		send_item(md5_pkg::MODE_FINAL, 8'h63);
		send_item(md5_pkg::MODE_NONE, 8'hff);
		send_item(md5_pkg::MODE_END, 8'h00);
		send_item(md5_pkg::MODE_DATA, 8'h00);
		send_item(md5_pkg::MODE_DATA, 8'hff);
		send_item(md5_pkg::MODE_NONE, 8'ha5);
		send_item(md5_pkg::MODE_DATA, 8'h80);
		send_item(md5_pkg::MODE_END, 8'h5a);
		send_item(md5_pkg::MODE_NONE, 8'h00);
		send_item(md5_pkg::MODE_FINAL, 8'h00);
	endtask

	// lengths around the pad boundary: one or two final compressions
	task automatic test_padding_edges();
		send_message(55, 1'b1, 1'b0);
		send_message(56, 1'b0, 1'b0);
		send_message(63, 1'b0, 1'b0);
		send_message(64, 1'b1, 1'b0);
	endtask

	// receiver holds off while the sender keeps offering, filling the queue
	task automatic test_backpressure();
		idle_on  = 1'b0;
		hold_off = 400;
		send_message(4, 1'b1, 1'b0);
		send_message(8, 1'b0, 1'b0);
		idle_on = 1'b1;
	endtask

	// random short messages with ignored beats mixed in
	task automatic test_random_messages();
		int sent;
		int len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			len = $urandom_range(0, 24);
			send_message(len, 1'($urandom), 1'b1);
			sent += len + 1;
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		idle_on    = 1'b1;
		errors     = 0;
		cycles     = 0;
		stall_left = 0;
		hold_off   = 0;
		md5_reset_state();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_short_messages();
		test_padding_edges();
		test_backpressure();
		test_random_messages();
		item_valid <= 1'b0;

		// drain outstanding digests, then let the block settle
		while (digest_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
